// File: rtl/core/qrs_pkg.sv
package qrs_pkg;

  localparam int DATA_W      = 32;
  localparam int FRAC_DEF    = 16;
  localparam int FRAC_MAX    = 24;
  // exact discriminant B^2 + 4|AC| never needs more than this
  localparam int DISC_W      = 2*DATA_W + 3;
  localparam int SQRT_W      = DATA_W + 2;
  localparam int SAT_W       = 2*DATA_W + FRAC_MAX + 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int ADDR_W      = 3;

  localparam logic REG_INPUT_FORM = 1'b0;

  typedef enum logic [1:0] {
    ST_NONE = 2'd0,
    ST_ONE  = 2'd1,
    ST_TWO  = 2'd2,
    ST_INF  = 2'd3
  } root_status_t;

  typedef enum logic [1:0] {
    KIND_FIXED,
    KIND_LINEAR,
    KIND_QUAD
  } item_kind_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] coef_a;
    logic signed [DATA_W-1:0] coef_b;
    logic signed [DATA_W-1:0] coef_c;
  } coefs_t;

  typedef struct packed {
    logic [1:0]               root_status;
    logic signed [DATA_W-1:0] root_low;
    logic signed [DATA_W-1:0] root_high;
    logic                     saturated;
  } roots_t;

  // classified item handed from front to back
  typedef struct packed {
    item_kind_t               kind;
    root_status_t             status;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic signed [DATA_W-1:0] c;
    logic [DISC_W-1:0]        disc;
    logic                     sat;
  } work_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic [DATA_W-1:0] mag_w(input logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? (~v + 1'b1) : v;
  endfunction

  // clip a magnitude to the signed range and apply the sign; msb is the clip flag
  function automatic logic [DATA_W:0] sat_fn(input logic neg, input logic [SAT_W-1:0] m);
    logic [SAT_W-1:0]  lim;
    logic              over;
    logic [DATA_W-1:0] mm;
    lim  = (SAT_W'(1) << (DATA_W-1)) - SAT_W'(!neg);
    over = m > lim;
    mm   = over ? lim[DATA_W-1:0] : m[DATA_W-1:0];
    return {over, neg ? (~mm + 1'b1) : mm};
  endfunction

endpackage

// File: rtl/core/qrs_front.sv
module qrs_front #(
  parameter int FRAC_BITS = qrs_pkg::FRAC_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            take,
  input  qrs_pkg::coefs_t coefs,
  input  logic            input_form,
  output logic            out_valid,
  output qrs_pkg::work_t  out_work
);
  import qrs_pkg::*;

  localparam int W = DATA_W;

  logic v0, v1, v2, v3, v4, v5;
  logic signed [W-1:0] a0, b0, c0, a1, b1, c1, a2, b2, c2, a3, b3, c3;
  logic signed [W-1:0] a4, b4, c4, a5, b5, c5;
  logic signed [W-1:0] bv2, bv3;
  logic f0, f1, f2, f3;
  logic fl2, fl3, fl4, fl5;
  logic [2*W-1:0] p_ab1, p_bb1, p_at3, bb5, ac5;
  logic [W-1:0] t2;

  logic [W:0] sat_b, sat_t, sat_u;
  logic signed [W:0] sum_c;
  logic signed [W-1:0] cv, b_sel, c_sel;
  logic over_c;

  logic [2*W+1:0] ac4;
  logic [DISC_W-1:0] d_add, d_sub;
  logic opp, lt;
  work_t w_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0; v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
      v4 <= 1'b0; v5 <= 1'b0; out_valid <= 1'b0;
    end else if (adv) begin
      v0 <= take; v1 <= v0; v2 <= v1; v3 <= v2;
      v4 <= v3; v5 <= v4; out_valid <= v5;
    end
  end

  // vertex expansion terms
  always_comb begin
    sat_b  = sat_fn(a1[W-1] == b1[W-1], SAT_W'(p_ab1 >> (FRAC_BITS-1)));
    sat_t  = sat_fn(1'b0, SAT_W'(p_bb1 >> FRAC_BITS));
    sat_u  = sat_fn(a3[W-1], SAT_W'(p_at3 >> FRAC_BITS));
    sum_c  = {sat_u[W-1], sat_u[W-1:0]} + {c3[W-1], c3};
    over_c = sum_c[W] != sum_c[W-1];
    cv     = over_c ? {sum_c[W], {(W-1){!sum_c[W]}}} : sum_c[W-1:0];
    b_sel  = f3 ? bv3 : b3;
    c_sel  = f3 ? cv : c3;
  end

  // discriminant and classification
  always_comb begin
    ac4   = {ac5, 2'b00};
    opp   = (c5 != '0) && (a5[W-1] != c5[W-1]);
    lt    = bb5 < ac4;
    d_add = DISC_W'(bb5) + DISC_W'(ac4);
    d_sub = DISC_W'(bb5) - DISC_W'(ac4);
    w_next.kind   = KIND_FIXED;
    w_next.status = ST_NONE;
    w_next.a      = a5;
    w_next.b      = b5;
    w_next.c      = c5;
    w_next.disc   = opp ? d_add : d_sub;
    w_next.sat    = fl5;
    if (a5 == '0) begin
      if (b5 == '0) begin
        w_next.status = (c5 == '0) ? ST_INF : ST_NONE;
      end else begin
        w_next.kind   = KIND_LINEAR;
        w_next.status = ST_ONE;
      end
    end else if (opp || !lt) begin
      w_next.kind   = KIND_QUAD;
      w_next.status = (w_next.disc == '0) ? ST_ONE : ST_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a0 <= coefs.coef_a; b0 <= coefs.coef_b; c0 <= coefs.coef_c; f0 <= input_form;

      p_ab1 <= mag_w(a0) * mag_w(b0);
      p_bb1 <= mag_w(b0) * mag_w(b0);
      a1 <= a0; b1 <= b0; c1 <= c0; f1 <= f0;

      bv2 <= sat_b[W-1:0];
      t2  <= sat_t[W-1:0];
      fl2 <= sat_b[W] | sat_t[W];
      a2 <= a1; b2 <= b1; c2 <= c1; f2 <= f1;

      p_at3 <= mag_w(a2) * t2;
      bv3 <= bv2; fl3 <= fl2;
      a3 <= a2; b3 <= b2; c3 <= c2; f3 <= f2;

      a4  <= a3;
      b4  <= b_sel;
      c4  <= c_sel;
      fl4 <= f3 & (fl3 | sat_u[W] | over_c);

      bb5 <= mag_w(b4) * mag_w(b4);
      ac5 <= mag_w(a4) * mag_w(c4);
      a5 <= a4; b5 <= b4; c5 <= c4; fl5 <= fl4;

      out_work <= w_next;
    end
  end

endmodule

// File: rtl/core/qrs_queue.sv
module qrs_queue #(
  parameter int DEPTH = qrs_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  qrs_pkg::work_t  wr,
  input  logic            pop,
  output qrs_pkg::work_t  rd,
  output qrs_pkg::qstat_t stat
);
  import qrs_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  work_t slots [DEPTH];
  logic [PW-1:0] wp, rp;
  logic [CW-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= (wp == PW'(DEPTH-1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == PW'(DEPTH-1)) ? '0 : rp + 1'b1;
      end
      cnt <= cnt + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= wr;
    end
  end

  assign rd         = slots[rp];
  assign stat.full  = cnt == CW'(DEPTH);
  assign stat.empty = cnt == '0;

endmodule

// File: rtl/core/qrs_sqrt.sv
module qrs_sqrt #(
  parameter int ROOT_W = qrs_pkg::SQRT_W
) (
  input  logic                  clk,
  input  logic [2*ROOT_W-1:0]   rad,
  output logic [ROOT_W-1:0]     root
);

  logic [2*ROOT_W-1:0] rad_q  [ROOT_W+1];
  logic [ROOT_W+1:0]   rem_q  [ROOT_W+1];
  logic [ROOT_W-1:0]   root_q [ROOT_W+1];

  assign rad_q[0]  = rad;
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;

  // one root bit per stage, two radicand bits brought down each time
  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    logic [ROOT_W+3:0] rem_sh, trial, rem_nx;
    logic              hit;

    always_comb begin
      rem_sh = {rem_q[i], rad_q[i][2*ROOT_W-1 -: 2]};
      trial  = {2'b00, root_q[i], 2'b01};
      hit    = rem_sh >= trial;
      rem_nx = hit ? rem_sh - trial : rem_sh;
    end

    always_ff @(posedge clk) begin
      rad_q[i+1]  <= rad_q[i] << 2;
      rem_q[i+1]  <= rem_nx[ROOT_W+1:0];
      root_q[i+1] <= {root_q[i][ROOT_W-2:0], hit};
    end
  end

  assign root = root_q[ROOT_W];

endmodule

// File: rtl/core/qrs_div.sv
module qrs_div #(
  parameter int NUM_W = qrs_pkg::DATA_W + 3 + qrs_pkg::FRAC_DEF,
  parameter int DEN_W = qrs_pkg::DATA_W + 1
) (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quot
);

  logic [NUM_W-1:0] num_q [NUM_W+1];
  logic [DEN_W-1:0] den_q [NUM_W+1];
  logic [DEN_W-1:0] rem_q [NUM_W+1];
  logic [NUM_W-1:0] quo_q [NUM_W+1];

  assign num_q[0] = num;
  assign den_q[0] = den;
  assign rem_q[0] = '0;
  assign quo_q[0] = '0;

  // restoring division, one quotient bit per stage
  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic [DEN_W:0] rem_sh, rem_nx;
    logic           hit;

    always_comb begin
      rem_sh = {rem_q[i], num_q[i][NUM_W-1]};
      hit    = rem_sh >= {1'b0, den_q[i]};
      rem_nx = hit ? rem_sh - {1'b0, den_q[i]} : rem_sh;
    end

    always_ff @(posedge clk) begin
      num_q[i+1] <= num_q[i] << 1;
      den_q[i+1] <= den_q[i];
      rem_q[i+1] <= rem_nx[DEN_W-1:0];
      quo_q[i+1] <= {quo_q[i][NUM_W-2:0], hit};
    end
  end

  assign quot = quo_q[NUM_W];

endmodule

// File: rtl/core/qrs_back.sv
module qrs_back #(
  parameter int FRAC_BITS = qrs_pkg::FRAC_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  qrs_pkg::work_t  in_work,
  output logic            done,
  output qrs_pkg::roots_t roots
);
  import qrs_pkg::*;

  localparam int W     = DATA_W;
  localparam int R     = SQRT_W;
  localparam int NW    = DATA_W + 4;
  localparam int NB    = NW - 1 + FRAC_BITS;
  localparam int DEN_W = DATA_W + 1;

  typedef struct packed {
    work_t w;
    logic  neg1;
    logic  neg2;
  } div_side_t;

  work_t     side_a [R+1];
  logic      va     [R+1];
  div_side_t side_b [NB+1];
  logic      vb     [NB+1];

  logic [R-1:0] s_root;
  work_t        we;
  logic signed [NW-1:0] bx, sx, n1, n2, m1, m2;
  logic [NB-1:0]    num1_n, num2_n, num1, num2, q1, q2;
  logic [DEN_W-1:0] den1_n, den2_n, den1, den2;
  div_side_t        sb_n;

  div_side_t sb;
  logic [W:0] sat1, sat2;
  logic signed [W-1:0] r1, r2;
  roots_t roots_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= R; k++) va[k] <= 1'b0;
    end else begin
      va[0] <= in_valid;
      for (int k = 1; k <= R; k++) va[k] <= va[k-1];
    end
    side_a[0] <= in_work;
    for (int k = 1; k <= R; k++) side_a[k] <= side_a[k-1];
  end

  qrs_sqrt #(.ROOT_W(R)) u_sqrt (
    .clk  (clk),
    .rad  ((2*R)'(side_a[0].disc)),
    .root (s_root)
  );

  // numerators -B -/+ sqrt(D), or -C for the linear case
  always_comb begin
    we = side_a[R];
    bx = NW'(we.b);
    sx = NW'(s_root);
    n1 = -bx - sx;
    n2 = -bx + sx;
    m1 = n1[NW-1] ? -n1 : n1;
    m2 = n2[NW-1] ? -n2 : n2;
    sb_n.w = we;
    if (we.kind == KIND_LINEAR) begin
      num1_n    = NB'(mag_w(we.c)) << FRAC_BITS;
      den1_n    = {1'b0, mag_w(we.b)};
      sb_n.neg1 = (we.c[W-1] == we.b[W-1]) && (we.c != '0);
    end else begin
      num1_n    = NB'(m1[NW-2:0]) << FRAC_BITS;
      den1_n    = {mag_w(we.a), 1'b0};
      sb_n.neg1 = n1[NW-1] != we.a[W-1];
    end
    num2_n    = NB'(m2[NW-2:0]) << FRAC_BITS;
    den2_n    = {mag_w(we.a), 1'b0};
    sb_n.neg2 = n2[NW-1] != we.a[W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= NB; k++) vb[k] <= 1'b0;
    end else begin
      vb[0] <= va[R];
      for (int k = 1; k <= NB; k++) vb[k] <= vb[k-1];
    end
    side_b[0] <= sb_n;
    for (int k = 1; k <= NB; k++) side_b[k] <= side_b[k-1];
    num1 <= num1_n;
    num2 <= num2_n;
    den1 <= den1_n;
    den2 <= den2_n;
  end

  qrs_div #(.NUM_W(NB), .DEN_W(DEN_W)) u_div_1 (
    .clk (clk), .num (num1), .den (den1), .quot (q1)
  );

  qrs_div #(.NUM_W(NB), .DEN_W(DEN_W)) u_div_2 (
    .clk (clk), .num (num2), .den (den2), .quot (q2)
  );

  always_comb begin
    sb   = side_b[NB];
    sat1 = sat_fn(sb.neg1, SAT_W'(q1));
    sat2 = sat_fn(sb.neg2, SAT_W'(q2));
    r1   = sat1[W-1:0];
    r2   = sat2[W-1:0];
    roots_n.root_status = sb.w.status;
    roots_n.root_low    = '0;
    roots_n.root_high   = '0;
    roots_n.saturated   = sb.w.sat;
    unique case (sb.w.kind)
      KIND_LINEAR: begin
        roots_n.root_low  = r1;
        roots_n.root_high = r1;
        roots_n.saturated = sb.w.sat | sat1[W];
      end
      KIND_QUAD: begin
        roots_n.root_low  = (r1 < r2) ? r1 : r2;
        roots_n.root_high = (r1 < r2) ? r2 : r1;
        roots_n.saturated = sb.w.sat | sat1[W] | sat2[W];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vb[NB];
    end
    roots <= roots_n;
  end

endmodule

// File: rtl/core/quadratic_root_solver_core.sv
// channel  | ports                          | transfer
// ---------+--------------------------------+------------------------------------
// coefs    | start, busy, coefs             | start && !busy at the clock edge
// roots    | done, roots                    | done high for one cycle per item
// config   | psel, penable, pwrite, paddr,  | write at access phase, pready
//          | pwdata, prdata, pready         | always high
//
// One item per cycle while busy is low. The bit-per-stage square root and the two
// bit-per-stage dividers make up most of the pipeline depth.
// rst is synchronous and clears all valid bits, the queue and input_form.
// The back end never stalls, so busy only rises if the queue is full and not draining.
module quadratic_root_solver_core #(
  parameter int FRAC_BITS = qrs_pkg::FRAC_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  qrs_pkg::coefs_t            coefs,
  output logic                       done,
  output qrs_pkg::roots_t            roots,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [qrs_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import qrs_pkg::*;

  logic   input_form;
  logic   adv;
  logic   f_valid;
  work_t  f_work;
  logic   q_push, q_pop;
  work_t  q_rd;
  qstat_t q_stat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_form <= 1'b0;
    end else if (psel && penable && pwrite && paddr[ADDR_W-1] == REG_INPUT_FORM) begin
      input_form <= pwdata[0];
    end
  end

  assign prdata = (paddr[ADDR_W-1] == REG_INPUT_FORM) ? {31'b0, input_form} : '0;

  assign q_pop  = !q_stat.empty;
  assign adv    = !q_stat.full || q_pop;
  assign busy   = !adv;
  assign q_push = f_valid && adv;

  qrs_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .take       (start && !busy),
    .coefs      (coefs),
    .input_form (input_form),
    .out_valid  (f_valid),
    .out_work   (f_work)
  );

  qrs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .wr   (f_work),
    .pop  (q_pop),
    .rd   (q_rd),
    .stat (q_stat)
  );

  qrs_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (q_pop),
    .in_work  (q_rd),
    .done     (done),
    .roots    (roots)
  );

`ifndef SYNTHESIS
  a_queue_no_overrun: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (!q_stat.full || q_pop))
    else $error("queue overrun");

  a_single_root: assert property (@(posedge clk) disable iff (rst)
    (done && roots.root_status == ST_ONE) |-> roots.root_low == roots.root_high)
    else $error("single root with differing values");

  a_no_root_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (roots.root_status == ST_NONE || roots.root_status == ST_INF))
      |-> (roots.root_low == '0 && roots.root_high == '0))
    else $error("roots not zero without a root");

  a_roots_ordered: assert property (@(posedge clk) disable iff (rst)
    (done && roots.root_status == ST_TWO) |-> roots.root_low <= roots.root_high)
    else $error("roots out of order");
`endif

endmodule
